### design/bloom_bit_transposer_assert.svh
// Assertion macros for the bloom bit transposer.
// Each macro checks on the rising edge of clk and is disabled while rst is high.
`ifndef BLOOM_BIT_TRANSPOSER_ASSERT_SVH
`define BLOOM_BIT_TRANSPOSER_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define BBT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define BBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bbt_pkg.sv
// ----------------------------------------------------------------------------
// bbt_pkg
// Sizes, word kinds and controller/datapath interface types of the bloom bit
// transposer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbt_pkg;

  // Store geometry
  localparam int BLOOM_BITS      = 2048;
  localparam int SECTION_LEDGERS = 4096;
  localparam int CHUNK_BITS      = 64;

  localparam int ROW_BYTES   = (SECTION_LEDGERS + 7) / 8;
  localparam int STORE_BYTES = BLOOM_BITS * ROW_BYTES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // Input field widths
  localparam int KIND_W   = 2;
  localparam int OFFS_W   = 12;
  localparam int CHUNK_W  = 5;
  localparam int BITS_W   = 64;
  localparam int ROW_IN_W = 11;
  localparam int BYTE_W   = 9;

  // Chunk bit counter and bloom row arithmetic
  localparam int BIT_W = (CHUNK_BITS > 1) ? $clog2(CHUNK_BITS) : 1;
  localparam int R_W   = CHUNK_W + BIT_W;

  // Highest bit position within a byte; column 0 of a byte sits here
  localparam int BYTE_MSB = 7;

  // Word kinds
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // latch the accepted word
    logic clr_init;    // restart the clear sweep at address zero
    logic add_step;    // process one chunk bit
    logic rd_issue;    // issue the row byte read
    logic rd_capture;  // capture the read data into the result register
    logic clr_step;    // zero one store byte
  } bbt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bit_last;    // chunk bit counter at its last position
    logic clr_last;    // clear sweep at the last store byte
  } bbt_stat_t;

endpackage

### design/bbt_datapath.sv
// ----------------------------------------------------------------------------
// bbt_datapath
// Row store, word registers, chunk bit counter, clear sweep and result
// register of the bloom bit transposer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bloom_bit_transposer_assert.svh"

module bbt_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  bbt_pkg::bbt_cmd_t             cmd,
  output bbt_pkg::bbt_stat_t            stat,
  input  logic [bbt_pkg::OFFS_W-1:0]    ledger_offset,
  input  logic [bbt_pkg::CHUNK_W-1:0]   chunk_index,
  input  logic [bbt_pkg::BITS_W-1:0]    chunk_bits,
  input  logic [bbt_pkg::ROW_IN_W-1:0]  row,
  input  logic [bbt_pkg::BYTE_W-1:0]    byte_index,
  output logic [7:0]                    row_byte,
  output logic                          done
);

  localparam int ADDR_W = bbt_pkg::ADDR_W;
  localparam int BIT_W  = bbt_pkg::BIT_W;
  localparam int R_W    = bbt_pkg::R_W;

  // Row store
  logic [7:0] mem [bbt_pkg::STORE_BYTES];

  // Latched word
  logic                          off_ok;
  logic [bbt_pkg::BYTE_W-1:0]    byte_pos;
  logic [7:0]                    mask;
  logic [bbt_pkg::CHUNK_W-1:0]   chunk_q;
  logic [bbt_pkg::CHUNK_BITS-1:0] bits_q;
  logic                          rd_ok;
  logic [ADDR_W-1:0]             rd_addr;

  // Counters and pipeline
  logic [BIT_W-1:0]  idx;
  logic [ADDR_W-1:0] clr_addr;
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        rdata;

  logic [R_W-1:0]    bloom_row;
  logic [ADDR_W-1:0] add_addr;
  logic              add_hit;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic [2:0]        mem_ops;

  // Bloom row and store address of the current chunk bit
  assign bloom_row = R_W'(chunk_q) * R_W'(bbt_pkg::CHUNK_BITS) + R_W'(idx);
  assign add_addr  = ADDR_W'(bloom_row) * ADDR_W'(bbt_pkg::ROW_BYTES) + ADDR_W'(byte_pos);
  assign add_hit   = cmd.add_step && bits_q[idx] && off_ok &&
                     (32'(bloom_row) < bbt_pkg::BLOOM_BITS);

  // Memory port selection
  assign re    = add_hit || cmd.rd_issue;
  assign raddr = cmd.rd_issue ? rd_addr : add_addr;
  assign we    = cmd.clr_step || wr_pend;
  assign waddr = cmd.clr_step ? clr_addr : wr_addr;
  assign wdata = cmd.clr_step ? 8'h00 : (rdata | mask);

  assign stat = '{bit_last: (idx == BIT_W'(bbt_pkg::CHUNK_BITS - 1)),
                  clr_last: (clr_addr == ADDR_W'(bbt_pkg::STORE_BYTES - 1))};

  assign mem_ops = {cmd.add_step, cmd.rd_issue, cmd.clr_step};

  // Store write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Store read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      off_ok   <= (ledger_offset < bbt_pkg::SECTION_LEDGERS);
      byte_pos <= bbt_pkg::BYTE_W'(ledger_offset >> 3);
      mask     <= 8'h01 << (3'(bbt_pkg::BYTE_MSB) - ledger_offset[2:0]);
      chunk_q  <= chunk_index;
      bits_q   <= chunk_bits[bbt_pkg::CHUNK_BITS-1:0];
      rd_ok    <= (row < bbt_pkg::BLOOM_BITS) && (byte_index < bbt_pkg::ROW_BYTES);
      rd_addr  <= ADDR_W'(row) * ADDR_W'(bbt_pkg::ROW_BYTES) + ADDR_W'(byte_index);
    end
  end

  // Advance the chunk bit counter and the clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.add_step) begin
        idx <= idx + BIT_W'(1);
      end
      if (cmd.clr_init) begin
        clr_addr <= '0;
      end else if (cmd.clr_step) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  // Register the write half of the read-modify-write behind its read
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= add_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (add_hit) begin
      wr_addr <= add_addr;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.rd_capture;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_capture) begin
      row_byte <= rd_ok ? rdata : 8'h00;
    end
  end

  // Checks
  `BBT_ASSERT_NOW(a_cmd_excl, 1'b1, $onehot0(mem_ops), "bbt: memory commands overlap")
  `BBT_ASSERT_NOW(a_wr_no_clear, wr_pend, !cmd.clr_step, "bbt: add write meets clear")
  `BBT_ASSERT_NOW(a_wr_after_step, wr_pend, $past(cmd.add_step), "bbt: write without step")
  `BBT_ASSERT_NOW(a_cap_after_issue, cmd.rd_capture, $past(cmd.rd_issue), "bbt: stray capture")
  `BBT_ASSERT_NEXT(a_load_clears_idx, cmd.load, idx == '0, "bbt: bit counter not restarted")

endmodule

### design/bbt_ctrl.sv
// ----------------------------------------------------------------------------
// bbt_ctrl
// Sequencer of the bloom bit transposer: decodes accepted words and steps the
// datapath through chunk bits, row reads and clear sweeps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbt_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bbt_pkg::KIND_W-1:0]  kind,
  input  bbt_pkg::bbt_stat_t          stat,
  output bbt_pkg::bbt_cmd_t           cmd,
  output logic                        busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_RD_ISSUE,
    ST_RD_CAPTURE,
    ST_CLEAR
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Decode commands from the state
  always_comb begin
    cmd            = '0;
    cmd.load       = accept;
    cmd.clr_init   = accept && (kind == bbt_pkg::KIND_CLEAR);
    cmd.add_step   = (state == ST_ADD);
    cmd.rd_issue   = (state == ST_RD_ISSUE);
    cmd.rd_capture = (state == ST_RD_CAPTURE);
    cmd.clr_step   = (state == ST_CLEAR);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (kind)
            bbt_pkg::KIND_ADD:   state_next = ST_ADD;
            bbt_pkg::KIND_READ:  state_next = ST_RD_ISSUE;
            bbt_pkg::KIND_CLEAR: state_next = ST_CLEAR;
            default:             state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (stat.bit_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_RD_ISSUE:   state_next = ST_RD_CAPTURE;
      ST_RD_CAPTURE: state_next = ST_IDLE;
      ST_CLEAR: begin
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state; reset starts the clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/bloom_bit_transposer.sv
// Add word: busy while every chunk bit is stepped; next word once busy falls.
// Read word: ST_RD_ISSUE reads the byte, ST_RD_CAPTURE registers row_byte and done.
// Clear word: one store byte zeroed per cycle, busy until all store bytes are zeroed.
// Reset starts the same clear sweep; busy stays high meanwhile.
// Throughput is set by the sequencer; the store has separate read and write ports.
// Results come with done for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// bloom_bit_transposer
// Corner-turns ledger bloom chunks into bit-sliced rows held in a byte store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bloom_bit_transposer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bbt_pkg::KIND_W-1:0]    kind,
  input  logic [bbt_pkg::OFFS_W-1:0]    ledger_offset,
  input  logic [bbt_pkg::CHUNK_W-1:0]   chunk_index,
  input  logic [bbt_pkg::BITS_W-1:0]    chunk_bits,
  input  logic [bbt_pkg::ROW_IN_W-1:0]  row,
  input  logic [bbt_pkg::BYTE_W-1:0]    byte_index,
  output logic [7:0]                    row_byte,
  output logic                          done
);

  bbt_pkg::bbt_cmd_t  cmd;
  bbt_pkg::bbt_stat_t stat;

  // Sequencer
  bbt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Store and word registers
  bbt_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .ledger_offset (ledger_offset),
    .chunk_index   (chunk_index),
    .chunk_bits    (chunk_bits),
    .row           (row),
    .byte_index    (byte_index),
    .row_byte      (row_byte),
    .done          (done)
  );

endmodule

### test/bbt_transpose_checker.sv
// ----------------------------------------------------------------------------
// bbt_transpose_checker
// Watches the word and result ports of the bloom bit transposer. It keeps its
// own copy of the bit-sliced row store, works out the row byte that every
// accepted read must return, and compares each strobed result with the oldest
// expected byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbt_transpose_checker
  import bbt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [KIND_W-1:0]   kind,
  input  logic [OFFS_W-1:0]   ledger_offset,
  input  logic [CHUNK_W-1:0]  chunk_index,
  input  logic [BITS_W-1:0]   chunk_bits,
  input  logic [ROW_IN_W-1:0] row,
  input  logic [BYTE_W-1:0]   byte_index,
  input  logic [7:0]          row_byte,
  input  logic                done,
  output int                  failures,
  output int                  pending
);

  // Sparse copy of the row store: an absent address reads as zero
  logic [7:0] column_bytes [int unsigned];
  logic [7:0] expected_row_bytes [$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  task automatic report_mismatch(input string what);
    failures++;
    $display("%0t: %s", $time, what);
  endtask

  // Set column offs in every row whose bloom bit is set in the chunk
  task automatic merge_chunk(input int unsigned offs, input int unsigned chunk,
                             input logic [BITS_W-1:0] bits);
    int unsigned bloom_row;
    int unsigned addr;
    logic [7:0]  mask;
    if (offs >= SECTION_LEDGERS) return;
    mask = 8'h01 << (BYTE_MSB - offs % 8);
    for (int i = 0; i < CHUNK_BITS; i++) begin
      bloom_row = chunk * CHUNK_BITS + i;
      if (bloom_row >= BLOOM_BITS) break;
      if (bits[i]) begin
        addr = bloom_row * ROW_BYTES + offs / 8;
        if (column_bytes.exists(addr)) column_bytes[addr] |= mask;
        else column_bytes[addr] = mask;
      end
    end
  endtask

  function automatic logic [7:0] lookup_row_byte(input int unsigned r,
                                                 input int unsigned b);
    int unsigned addr;
    addr = r * ROW_BYTES + b;
    if (r < BLOOM_BITS && b < ROW_BYTES && column_bytes.exists(addr))
      return column_bytes[addr];
    return 8'h00;
  endfunction

  always @(posedge clk) begin : watch
    logic [7:0] want;
    if (!rst) begin
      // Retire the oldest read before taking a new word at the same edge
      if (done) begin
        if (expected_row_bytes.size() == 0) begin
          report_mismatch($sformatf("row_byte %02h with no read outstanding", row_byte));
        end else begin
          want = expected_row_bytes.pop_front();
          if (row_byte !== want)
            report_mismatch($sformatf("row_byte %02h, expected %02h", row_byte, want));
        end
      end
      // Advance the store copy on every accepted word
      if (start && !busy) begin
        case (kind)
          KIND_ADD: begin
            merge_chunk(32'(ledger_offset), 32'(chunk_index), chunk_bits);
          end
          KIND_READ: begin
            expected_row_bytes.push_back(lookup_row_byte(32'(row), 32'(byte_index)));
          end
          KIND_CLEAR: begin
            column_bytes.delete();
          end
          default: ;
        endcase
      end
      pending = expected_row_bytes.size();
    end
  end

endmodule

### test/tb_bloom_bit_transposer.sv
// ----------------------------------------------------------------------------
// tb_bloom_bit_transposer
// Drives add, read, clear and unused words into the bloom bit transposer with
// random gaps and hands the result checking to bbt_transpose_checker. Adds are
// concentrated on a few columns so that most reads land on populated bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bloom_bit_transposer;
  import bbt_pkg::*;

  // The one kind code the block leaves unused
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam int RANDOM_WORDS  = 1830;
  localparam int IDLE_PERCENT  = 36;
  localparam int DRAIN_CYCLES  = 16;
  // Reset sweep plus one clear sweep plus the words, with headroom of roughly three times
  localparam int CYCLE_LIMIT   = 7_000_000;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [KIND_W-1:0]   kind;
  logic [OFFS_W-1:0]   ledger_offset;
  logic [CHUNK_W-1:0]  chunk_index;
  logic [BITS_W-1:0]   chunk_bits;
  logic [ROW_IN_W-1:0] row;
  logic [BYTE_W-1:0]   byte_index;
  logic [7:0]          row_byte;
  logic                done;

  int failures;
  int pending;
  int cycles = 0;
  bit steady = 1'b0;
  int last_offset = 0;
  int last_chunk = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bloom_bit_transposer i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .ledger_offset (ledger_offset),
    .chunk_index   (chunk_index),
    .chunk_bits    (chunk_bits),
    .row           (row),
    .byte_index    (byte_index),
    .row_byte      (row_byte),
    .done          (done)
  );

  bbt_transpose_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .ledger_offset (ledger_offset),
    .chunk_index   (chunk_index),
    .chunk_bits    (chunk_bits),
    .row           (row),
    .byte_index    (byte_index),
    .row_byte      (row_byte),
    .done          (done),
    .failures      (failures),
    .pending       (pending)
  );

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [BITS_W-1:0] noise64();
    return {$urandom, $urandom};
  endfunction

  // Offer one word from a falling edge and hold it until it is taken
  task automatic send_word(input logic [KIND_W-1:0] k, input int offs, input int chunk,
                           input logic [BITS_W-1:0] bits, input int r, input int b);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    kind          <= k;
    ledger_offset <= OFFS_W'(offs);
    chunk_index   <= CHUNK_W'(chunk);
    chunk_bits    <= bits;
    row           <= ROW_IN_W'(r);
    byte_index    <= BYTE_W'(b);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic add_chunk(input int offs, input int chunk, input logic [BITS_W-1:0] bits);
    send_word(KIND_ADD, offs, chunk, bits, $urandom_range(0, 2047), $urandom_range(0, 511));
    last_offset = offs;
    last_chunk  = chunk;
  endtask

  task automatic read_byte(input int r, input int b);
    send_word(KIND_READ, $urandom_range(0, 4095), $urandom_range(0, 31), noise64(), r, b);
  endtask

  task automatic send_noise(input logic [KIND_W-1:0] k);
    send_word(k, $urandom_range(0, 4095), $urandom_range(0, 31), noise64(),
              $urandom_range(0, 2047), $urandom_range(0, 511));
  endtask

  initial begin : stimulus
    int sent;
    int pick;
    int offs;
    logic [BITS_W-1:0] bits;

    rst           = 1'b1;
    start         = 1'b0;
    kind          = KIND_ADD;
    ledger_offset = '0;
    chunk_index   = '0;
    chunk_bits    = '0;
    row           = '0;
    byte_index    = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty store, corner columns and rows, unused kind, clear
    read_byte(0, 0);
    read_byte(2047, 511);
    add_chunk(0, 0, {BITS_W{1'b1}});
    add_chunk(4095, 31, {BITS_W{1'b1}});
    add_chunk(7, 0, 64'h8000_0000_0000_0001);
    add_chunk(2048, 15, '0);
    add_chunk(9, 3, 64'hA5A5_5A5A_F00F_0FF0);
    read_byte(0, 0);
    read_byte(63, 0);
    read_byte(1, 0);
    read_byte(2047, 511);
    read_byte(1984, 511);
    read_byte(192, 1);
    read_byte(255, 1);
    send_noise(KIND_SPARE);
    read_byte(0, 0);
    send_noise(KIND_CLEAR);
    read_byte(0, 0);
    read_byte(2047, 511);
    add_chunk(4095, 31, 64'h8000_0000_0000_0000);
    read_byte(2047, 511);
    read_byte(2046, 511);

    // Random: adds crowd into the first three bytes of every row
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      steady = (sent >= 700 && sent < 1000);
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_noise(KIND_SPARE);
      end else if (pick < 54) begin
        offs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 23);
        bits = noise64();
        if ($urandom_range(0, 3) == 0) bits &= noise64();
        add_chunk(offs, $urandom_range(0, 31), bits);
        sent++;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 3) read_byte(last_chunk * CHUNK_BITS + $urandom_range(0, 63), last_offset / 8);
        else if (pick < 8) read_byte($urandom_range(0, 2047), $urandom_range(0, 2));
        else read_byte($urandom_range(0, 2047), $urandom_range(0, 511));
        sent++;
      end
    end

    // Drop start and let the last results drain
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
